FILE: rtl/ncv_pkg.sv
// ----------------------------------------------------------------------------
// ncv_pkg
// Types and fixed constants shared by the normalised convolution core.
// ----------------------------------------------------------------------------
package ncv_pkg;

	localparam int WBITS   = 14;  // effective width, up to 8192
	localparam int KBITS   = 4;   // effective kernel side, up to 15
	localparam int QCOLW   = 13;  // column field of a queued request
	localparam int QRMW    = 4;   // ring row field of a queued request
	localparam int RES_W   = 38;

	typedef enum logic [1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_KSIZE  = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		REQ_COEF  = 1'b0,
		REQ_PIXEL = 1'b1
	} req_kind_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_RD,
		B_MUL,
		B_SUM,
		B_ACC,
		B_DIV,
		B_OUT
	} back_state_t;

	typedef struct packed {
		logic               req_type;
		logic [2:0]         coef_row;
		logic [2:0]         coef_col;
		logic signed [15:0] coef_value;
		logic signed [15:0] pixel_value;
	} item_t;

	typedef struct packed {
		logic signed [RES_W-1:0] filtered_value;
		logic [15:0]             out_row;
		logic [9:0]              out_col;
		logic                    div_zero;
		logic                    last_in_frame;
	} result_t;

	typedef struct packed {
		logic               req_type;
		logic [2:0]         coef_row;
		logic [2:0]         coef_col;
		logic signed [15:0] coef_value;
		logic signed [15:0] pixel_value;
		logic [QCOLW-1:0]   col;
		logic [QRMW-1:0]    rowmod;
		logic               emit;
		logic [15:0]        out_row;
		logic [9:0]         out_col;
		logic               last;
	} qitem_t;

endpackage

FILE: rtl/ncv_fifo.sv
// ----------------------------------------------------------------------------
// ncv_fifo
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module ncv_fifo
	import ncv_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qitem_t wdata,
	output logic   full,
	input  logic   pop,
	output logic   empty,
	output qitem_t rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	qitem_t          mem_q [DEPTH];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + AW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (AW+1)'(1);
			end
		end
	end

endmodule

FILE: rtl/ncv_front.sv
// ----------------------------------------------------------------------------
// ncv_front
// Accepts requests, tracks the raster position and tags each pixel with
// its window position before it is queued.
// ----------------------------------------------------------------------------
module ncv_front
	import ncv_pkg::*;
#(
	parameter int MAX_KERNEL = 5,
	parameter int MAX_WIDTH  = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             restart,
	input  logic [WBITS-1:0] eff_w,
	input  logic [15:0]      eff_h,
	input  logic [KBITS-1:0] eff_k,
	input  logic             item_valid,
	output logic             item_ready,
	input  item_t            item,
	input  logic             q_full,
	output logic             push,
	output qitem_t           qitem
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RMW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

	logic [CW-1:0]    col_q;
	logic [15:0]      row_q;
	logic [RMW-1:0]   rm_q;
	logic [WBITS-1:0] colp1;
	logic [16:0]      rowp1;

	assign item_ready = !q_full;
	assign push       = item_valid && item_ready;
	assign colp1      = WBITS'(col_q) + WBITS'(1);
	assign rowp1      = {1'b0, row_q} + 17'd1;

	always_comb begin
		qitem.req_type    = item.req_type;
		qitem.coef_row    = item.coef_row;
		qitem.coef_col    = item.coef_col;
		qitem.coef_value  = item.coef_value;
		qitem.pixel_value = item.pixel_value;
		qitem.col         = QCOLW'(col_q);
		qitem.rowmod      = QRMW'(rm_q);
		qitem.emit        = (rowp1 >= 17'(eff_k)) && (colp1 >= WBITS'(eff_k));
		qitem.out_row     = 16'(rowp1 - 17'(eff_k));
		qitem.out_col     = 10'(colp1 - WBITS'(eff_k));
		qitem.last        = (rowp1 == {1'b0, eff_h}) && (colp1 == eff_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			rm_q  <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
			rm_q  <= '0;
		end else if (push && (item.req_type == REQ_PIXEL)) begin
			if (colp1 >= eff_w) begin
				col_q <= '0;
				if (rowp1 >= {1'b0, eff_h}) begin
					row_q <= '0;
					rm_q  <= '0;
				end else begin
					row_q <= row_q + 16'd1;
					rm_q  <= (rm_q == RMW'(MAX_KERNEL-1)) ? '0 : rm_q + RMW'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

FILE: rtl/ncv_div.sv
// ----------------------------------------------------------------------------
// ncv_div
// Signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module ncv_div #(
	parameter int AW = 37,
	parameter int KW = 21
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [AW-1:0] dividend,
	input  logic signed [KW-1:0] divisor,
	output logic                 busy,
	output logic                 done,
	output logic signed [AW-1:0] quotient,
	output logic                 dz
);

	localparam int CNW = $clog2(AW+1);

	logic [AW-1:0]  quo_q;
	logic [KW-1:0]  rem_q, d_q;
	logic [CNW-1:0] cnt_q;
	logic           neg_q, busy_q, done_q;
	logic [KW:0]    trial;
	logic           fits;

	assign trial    = {rem_q, quo_q[AW-1]};
	assign fits     = (trial >= {1'b0, d_q});
	assign busy     = busy_q;
	assign done     = done_q;
	assign dz       = (d_q == '0);
	assign quotient = dz ? '0 : (neg_q ? -$signed(quo_q) : $signed(quo_q));

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[AW-1] ? AW'(-dividend) : AW'(dividend);
			d_q   <= divisor[KW-1] ? KW'(-divisor) : KW'(divisor);
			rem_q <= '0;
			neg_q <= dividend[AW-1] ^ divisor[KW-1];
		end else if (busy_q) begin
			rem_q <= fits ? KW'(trial - {1'b0, d_q}) : KW'(trial);
			quo_q <= {quo_q[AW-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(AW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNW'(1);
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/ncv_back.sv
// ----------------------------------------------------------------------------
// ncv_back
// Executes queued requests: kernel writes, line memory, window, products,
// sums and division, and holds the result register.
// ----------------------------------------------------------------------------
module ncv_back
	import ncv_pkg::*;
#(
	parameter int MAX_KERNEL = 5,
	parameter int MAX_WIDTH  = 1024,
	parameter int DATA_BITS  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [KBITS-1:0] eff_k,
	input  logic             q_empty,
	input  qitem_t           qi,
	output logic             pop,
	output logic             res_valid,
	input  logic             res_ready,
	output result_t          res
);

	localparam int KB  = MAX_KERNEL;
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RMW = (KB > 1) ? $clog2(KB) : 1;
	localparam int PW  = 2 * DATA_BITS;
	localparam int AW  = PW + $clog2(KB * KB + 1);
	localparam int KW  = DATA_BITS + $clog2(KB * KB + 1);

	back_state_t state_q, state_d;

	logic signed [DATA_BITS-1:0] ker_q  [KB][KB];
	logic signed [DATA_BITS-1:0] win_q  [KB][KB];
	logic signed [DATA_BITS-1:0] alw    [KB][KB];
	logic signed [DATA_BITS-1:0] bank_rd[KB];
	logic signed [PW-1:0]        prod_q [KB][KB];
	logic signed [DATA_BITS-1:0] kval_q [KB][KB];
	logic signed [AW-1:0]        rs_q   [KB];
	logic signed [KW-1:0]        ks_q   [KB];
	logic signed [AW-1:0]        rsum   [KB];
	logic signed [KW-1:0]        ksr    [KB];
	logic [RMW-1:0]              bsel   [KB];

	logic signed [DATA_BITS-1:0] pix_q;
	logic [RMW-1:0]              rm_q;
	logic                        emit_q;
	logic [15:0]                 orow_q;
	logic [9:0]                  ocol_q;
	logic                        last_q;

	logic                        mem_we;
	logic [CW-1:0]               mem_addr;
	logic                        ker_we;
	logic                        div_start, div_busy, div_done, div_dz;
	logic signed [AW-1:0]        acc, div_q;
	logic signed [KW-1:0]        ksum;
	logic                        res_valid_q, load_res;
	result_t                     res_q;
	int                          base;

	assign mem_addr  = CW'(qi.col);
	assign base      = KB - int'(eff_k);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// One bank per ring row of the line store.
	for (genvar b = 0; b < KB; b++) begin : g_bank
		logic signed [DATA_BITS-1:0] mem [MAX_WIDTH];
		logic signed [DATA_BITS-1:0] rd_q;
		always_ff @(posedge clk) begin
			if (mem_we && (RMW'(qi.rowmod) == RMW'(b))) begin
				mem[mem_addr] <= DATA_BITS'(qi.pixel_value);
			end
			rd_q <= mem[mem_addr];
		end
		assign bank_rd[b] = rd_q;
	end

	// Window row r takes the ring row r+1 places after the current one.
	always_comb begin
		int t;
		t = 0;
		for (int r = 0; r < KB; r++) begin
			t = int'(rm_q) + 1 + r;
			if (t >= KB) begin
				t = t - KB;
			end
			bsel[r] = RMW'(t);
		end
	end

	// The kernel in use sits in the bottom right corner of the window.
	always_comb begin
		for (int r = 0; r < KB; r++) begin
			for (int c = 0; c < KB; c++) begin
				alw[r][c] = '0;
				for (int o = 0; o < KB; o++) begin
					if ((o == base) && (r + o < KB) && (c + o < KB)) begin
						alw[r][c] = win_q[r+o][c+o];
					end
				end
			end
		end
	end

	// Row totals of the registered products, captured at the end of B_SUM.
	always_comb begin
		for (int r = 0; r < KB; r++) begin
			rsum[r] = '0;
			ksr[r]  = '0;
			for (int c = 0; c < KB; c++) begin
				rsum[r] = rsum[r] + AW'(prod_q[r][c]);
				ksr[r]  = ksr[r] + KW'(kval_q[r][c]);
			end
		end
	end

	always_comb begin
		acc  = '0;
		ksum = '0;
		for (int r = 0; r < KB; r++) begin
			acc  = acc + rs_q[r];
			ksum = ksum + ks_q[r];
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		mem_we    = 1'b0;
		ker_we    = 1'b0;
		div_start = 1'b0;
		load_res  = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					if (qi.req_type == REQ_COEF) begin
						ker_we = (qi.coef_row < 3'(KB)) && (qi.coef_col < 3'(KB));
					end else begin
						mem_we  = 1'b1;
						state_d = B_RD;
					end
				end
			end
			B_RD: begin
				state_d = emit_q ? B_MUL : B_IDLE;
			end
			B_MUL: begin
				state_d = B_SUM;
			end
			B_SUM: begin
				state_d = B_ACC;
			end
			B_ACC: begin
				div_start = 1'b1;
				state_d   = B_DIV;
			end
			B_DIV: begin
				if (div_done) begin
					state_d = B_OUT;
				end
			end
			B_OUT: begin
				if (!res_valid_q || res_ready) begin
					load_res = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pix_q  <= DATA_BITS'(qi.pixel_value);
			rm_q   <= RMW'(qi.rowmod);
			emit_q <= qi.emit;
			orow_q <= qi.out_row;
			ocol_q <= qi.out_col;
			last_q <= qi.last;
		end
		if (state_q == B_MUL) begin
			for (int r = 0; r < KB; r++) begin
				for (int c = 0; c < KB; c++) begin
					if ((r < int'(eff_k)) && (c < int'(eff_k))) begin
						prod_q[r][c] <= PW'(alw[r][c]) * PW'(ker_q[r][c]);
						kval_q[r][c] <= ker_q[r][c];
					end else begin
						prod_q[r][c] <= '0;
						kval_q[r][c] <= '0;
					end
				end
			end
		end
		if (state_q == B_SUM) begin
			for (int r = 0; r < KB; r++) begin
				rs_q[r] <= rsum[r];
				ks_q[r] <= ksr[r];
			end
		end
	end

	ncv_div #(
		.AW(AW),
		.KW(KW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(acc),
		.divisor (ksum),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(div_q),
		.dz      (div_dz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < KB; r++) begin
				for (int c = 0; c < KB; c++) begin
					ker_q[r][c] <= '0;
					win_q[r][c] <= '0;
				end
			end
			res_valid_q <= 1'b0;
		end else begin
			if (ker_we) begin
				ker_q[RMW'(qi.coef_row)][RMW'(qi.coef_col)] <=
					DATA_BITS'(qi.coef_value);
			end
			if (state_q == B_RD) begin
				for (int r = 0; r < KB; r++) begin
					for (int c = 0; c + 1 < KB; c++) begin
						win_q[r][c] <= win_q[r][c+1];
					end
					win_q[r][KB-1] <= (r == KB - 1) ? pix_q : bank_rd[bsel[r]];
				end
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q.filtered_value <= RES_W'(div_q);
			res_q.div_zero       <= div_dz;
			res_q.out_row        <= orow_q;
			res_q.out_col        <= ocol_q;
			res_q.last_in_frame  <= last_q;
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == B_IDLE))
		else $error("request taken from the queue outside idle");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == B_DIV))
		else $error("divider running outside the divide state");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.div_zero) |-> (res_q.filtered_value == '0))
		else $error("zero kernel sum with a non-zero result");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_res |-> (!res_valid_q || res_ready))
		else $error("result register overwritten before it was taken");

endmodule

FILE: rtl/normalized_valid_conv2d_core.sv
// ----------------------------------------------------------------------------
// normalized_valid_conv2d_core
// Valid-region 2D convolution of a raster pixel stream, normalised by the
// sum of the kernel entries in use.
// ----------------------------------------------------------------------------
//  channel | signals                              | moves
//  --------+--------------------------------------+---------------------------
//  item    | item_valid, item_ready, item         | kernel write or pixel
//  res     | res_valid, res_ready, res            | one filtered result
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | register write
//
// A kernel write is done in the idle state of the back part, a pixel with
// no window passes through B_RD, and a pixel that completes a window goes
// through B_RD, B_MUL, B_SUM, B_ACC, B_DIV and B_OUT, waiting in B_DIV on
// the one-bit-per-cycle divider and in B_OUT for the result register.
// A four-entry queue lets the front take requests while the back works.
// Reset clears kernel, window, position and control; the line store
// needs no clearing pass.
// ----------------------------------------------------------------------------
module normalized_valid_conv2d_core
	import ncv_pkg::*;
#(
	parameter int MAX_KERNEL = 5,
	parameter int MAX_WIDTH  = 1024,
	parameter int DATA_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        res_valid,
	input  logic        res_ready,
	output result_t     res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [10:0]      width_q;
	logic [15:0]      height_q;
	logic [2:0]       ksize_q;
	logic [WBITS-1:0] eff_w;
	logic [15:0]      eff_h;
	logic [KBITS-1:0] eff_k;
	logic             cfg_wr, restart;
	logic             push, q_full, q_empty, pop;
	qitem_t           qin, qout;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign restart   = cfg_wr && ((cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT)
		|| (cfg_index == CFG_KSIZE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1024;
			height_q <= 16'd1024;
			ksize_q  <= 3'd3;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data[10:0];
				CFG_HEIGHT: height_q <= cfg_data;
				CFG_KSIZE:  ksize_q  <= cfg_data[2:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			eff_w = WBITS'(1);
		end else if (WBITS'(width_q) > WBITS'(MAX_WIDTH)) begin
			eff_w = WBITS'(MAX_WIDTH);
		end else begin
			eff_w = WBITS'(width_q);
		end
		eff_h = (height_q == '0) ? 16'd1 : height_q;
		if (ksize_q == '0) begin
			eff_k = KBITS'(1);
		end else if (KBITS'(ksize_q) > KBITS'(MAX_KERNEL)) begin
			eff_k = KBITS'(MAX_KERNEL);
		end else begin
			eff_k = KBITS'(ksize_q);
		end
	end

	ncv_front #(
		.MAX_KERNEL(MAX_KERNEL),
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.eff_w     (eff_w),
		.eff_h     (eff_h),
		.eff_k     (eff_k),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.q_full    (q_full),
		.push      (push),
		.qitem     (qin)
	);

	ncv_fifo #(
		.DEPTH(4)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (qin),
		.full  (q_full),
		.pop   (pop),
		.empty (q_empty),
		.rdata (qout)
	);

	ncv_back #(
		.MAX_KERNEL(MAX_KERNEL),
		.MAX_WIDTH (MAX_WIDTH),
		.DATA_BITS (DATA_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.eff_k    (eff_k),
		.q_empty  (q_empty),
		.qi       (qout),
		.pop      (pop),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

endmodule
